FILE: rtl/bracket_balance_stack_top_defines.svh
// ----------------------------------------------------------------------------
// Bracket balance stack - assertion macros
// Shared assertion forms for the bracket balance stack; clocked on clk,
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_STACK_TOP_DEFINES_SVH
`define BRACKET_BALANCE_STACK_TOP_DEFINES_SVH

// Same-cycle implication
`define BBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define BBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bbs_pkg.sv
// ----------------------------------------------------------------------------
// Bracket balance stack - package
// Commands, bracket characters, walker control types and the opener lookup.
// ----------------------------------------------------------------------------
package bbs_pkg;

	// Default stack depth
	localparam int BBS_DEPTH = 256;

	// Command codes
	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_POP   = 2'd1;
	localparam logic [1:0] CMD_TOP   = 2'd2;
	localparam logic [1:0] CMD_CHECK = 2'd3;

	// Bracket characters
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_NONE   = 8'h00;

	// Control from the sequencer to the match walker
	typedef struct packed {
		logic clear;
		logic step;
	} bbs_walk_ctl_t;

	// Status from the match walker
	typedef struct packed {
		logic reload;
		logic empty;
	} bbs_walk_sts_t;

	// Opener paired with a closing bracket, CH_NONE for any other byte
	function automatic logic [7:0] opener_of(input logic [7:0] b);
		logic [7:0] op;
		op = CH_NONE;
		case (b)
			CH_RPAREN: op = CH_LPAREN;
			CH_RBRACE: op = CH_LBRACE;
			CH_RBRACK: op = CH_LBRACK;
			default:   op = CH_NONE;
		endcase
		return op;
	endfunction

endpackage

FILE: rtl/bracket_balance_stack_top.sv
// ----------------------------------------------------------------------------
// Bracket balance stack - top level
// Byte stack with push, pop, read top and a bracket balance check.
//
//   Channel | Handshake            | Beat contents
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_ready  | command, char_in
//   out     | out_valid / out_ready| top_char, top_valid, balanced, overflow
//
// Push and read top go from accept to the final state; pop passes a load
// state first when the new top must be fetched from the byte memory.
// A check reads each stored byte in turn: each byte costs one read of the
// single read port of the byte memory and one step of the match walker.
// in_ready is high only while the sequencer is idle; a result waiting on
// out_ready holds the sequencer in its final state.
// Reset clears the sequencer state, counts and flags; the memories need no clearing pass.
// ----------------------------------------------------------------------------
`include "bracket_balance_stack_top_defines.svh"

module bracket_balance_stack_top
	import bbs_pkg::*;
#(
	parameter int DEPTH = BBS_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [7:0] char_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] top_char,
	output logic       top_valid,
	output logic       balanced,
	output logic       overflow
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Sequencer states
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_POP_LD   = 3'd1;
	localparam logic [2:0] ST_CHK_RD   = 3'd2;
	localparam logic [2:0] ST_CHK_EVAL = 3'd3;
	localparam logic [2:0] ST_CHK_END  = 3'd4;
	localparam logic [2:0] ST_FIN      = 3'd5;

	logic [2:0]    state_q;
	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_q;
	logic [7:0]    top_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic          bal_q;
	logic          ovf_q;
	logic          out_valid_q;
	logic [7:0]    out_top_q;
	logic          out_tv_q;
	logic          out_bal_q;
	logic          out_ovf_q;

	logic          in_beat;
	logic          out_free;
	logic          do_push;
	logic          pop_fetch;
	logic          mem_re;
	logic [CW-1:0] pop_addr;
	logic [AW-1:0] rd_addr;
	bbs_walk_ctl_t walk_ctl;
	bbs_walk_sts_t walk_sts;

	assign in_ready = (state_q == ST_IDLE);
	assign in_beat  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Decode the accepted beat
	assign do_push   = in_beat && (command == CMD_PUSH) && (cnt_q < CW'(DEPTH));
	assign pop_fetch = in_beat && (command == CMD_POP) && (cnt_q >= CW'(2));
	assign pop_addr  = cnt_q - CW'(2);
	assign mem_re    = pop_fetch || (state_q == ST_CHK_RD);
	assign rd_addr   = (state_q == ST_CHK_RD) ? idx_q[AW-1:0] : pop_addr[AW-1:0];

	// Byte memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[cnt_q[AW-1:0]] <= char_in;
		end
		if (mem_re) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Hold the top byte: take pushed bytes, reload after a pop
	always_ff @(posedge clk) begin
		if (do_push) begin
			top_q <= char_in;
		end else if (state_q == ST_POP_LD) begin
			top_q <= rd_q;
		end
	end

	// Drive the match walker
	assign walk_ctl.clear = in_beat && (command == CMD_CHECK);
	assign walk_ctl.step  = (state_q == ST_CHK_EVAL);

	bbs_match_walker #(
		.DEPTH (DEPTH)
	) u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (walk_ctl),
		.data   (rd_q),
		.sts    (walk_sts)
	);

	// Sequencer and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			bal_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						bal_q <= 1'b0;
						ovf_q <= 1'b0;
						idx_q <= '0;
						state_q <= ST_FIN;
						case (command)
							CMD_PUSH: begin
								if (cnt_q < CW'(DEPTH)) begin
									cnt_q <= cnt_q + CW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							CMD_POP: begin
								if (cnt_q != '0) begin
									cnt_q <= cnt_q - CW'(1);
								end
								if (cnt_q >= CW'(2)) begin
									state_q <= ST_POP_LD;
								end
							end
							CMD_CHECK: begin
								if (cnt_q == '0) begin
									bal_q <= 1'b1;
								end else begin
									state_q <= ST_CHK_RD;
								end
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_POP_LD: begin
					state_q <= ST_FIN;
				end
				ST_CHK_RD: begin
					state_q <= ST_CHK_EVAL;
				end
				ST_CHK_EVAL: begin
					idx_q <= idx_q + CW'(1);
					if ((idx_q + CW'(1)) == cnt_q) begin
						state_q <= ST_CHK_END;
					end else begin
						state_q <= ST_CHK_RD;
					end
				end
				ST_CHK_END: begin
					bal_q   <= walk_sts.empty;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output valid: set on a result, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_top_q <= (cnt_q != '0) ? top_q : 8'h00;
			out_tv_q  <= (cnt_q != '0);
			out_bal_q <= bal_q;
			out_ovf_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign top_char  = out_top_q;
	assign top_valid = out_tv_q;
	assign balanced  = out_bal_q;
	assign overflow  = out_ovf_q;

	// Checks
	`BBS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "stack count beyond depth")
	`BBS_ASSERT_NOW(a_step_no_reload, walk_ctl.step, !walk_sts.reload, "walker stepped during reload")
	`BBS_ASSERT_NEXT(a_fin_hold, (state_q == ST_FIN) && out_valid_q && !out_ready, state_q == ST_FIN, "result dropped while output busy")
	`BBS_ASSERT_NEXT(a_empty_check, in_beat && (command == CMD_CHECK) && (cnt_q == '0), (state_q == ST_FIN) && bal_q, "empty check not balanced")

endmodule

FILE: rtl/bbs_match_walker.sv
// ----------------------------------------------------------------------------
// Bracket balance stack - match walker
// Matching stack with its compare unit: takes one byte per step, pops a
// matching opener or pushes the byte. A pop reloads the cached top from
// memory in the following cycle.
// ----------------------------------------------------------------------------
module bbs_match_walker
	import bbs_pkg::*;
#(
	parameter int DEPTH = BBS_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bbs_walk_ctl_t ctl,
	input  logic [7:0]    data,
	output bbs_walk_sts_t sts
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_q;
	logic [7:0]    mtop_q;
	logic [CW-1:0] mc_q;
	logic          reload_q;
	logic [7:0]    op;
	logic          pop_hit;
	logic          push_hit;
	logic [CW-1:0] below_top;

	// Compare the byte against the cached top of the matching stack
	assign op        = opener_of(data);
	assign pop_hit   = ctl.step && (op != CH_NONE) && (mc_q != '0) && (mtop_q == op);
	assign push_hit  = ctl.step && !pop_hit && (mc_q < CW'(DEPTH));
	assign below_top = mc_q - CW'(2);

	// Advance the match count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q     <= '0;
			reload_q <= 1'b0;
		end else begin
			reload_q <= pop_hit;
			if (ctl.clear) begin
				mc_q <= '0;
			end else if (pop_hit) begin
				mc_q <= mc_q - CW'(1);
			end else if (push_hit) begin
				mc_q <= mc_q + CW'(1);
			end
		end
	end

	// Store pushed bytes; fetch the entry below the top on a pop
	always_ff @(posedge clk) begin
		if (push_hit) begin
			mem[mc_q[AW-1:0]] <= data;
		end
		if (pop_hit && (mc_q >= CW'(2))) begin
			rd_q <= mem[below_top[AW-1:0]];
		end
	end

	// Hold the cached top
	always_ff @(posedge clk) begin
		if (push_hit) begin
			mtop_q <= data;
		end else if (reload_q) begin
			mtop_q <= rd_q;
		end
	end

	assign sts.reload = reload_q;
	assign sts.empty  = (mc_q == '0);

endmodule

FILE: dv/bracket_stack_checker.sv
// ----------------------------------------------------------------------------
// Bracket balance stack - result checker
// Watches both channels of the bracket balance stack. Every accepted command
// beat runs through a local copy of the byte stack to predict its result
// beat; every accepted result beat is compared field by field with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module bracket_stack_checker
	import bbs_pkg::*;
#(
	parameter int DEPTH = BBS_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] command,
	input  logic [7:0] char_in,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] top_char,
	input  logic       top_valid,
	input  logic       balanced,
	input  logic       overflow,
	output int         mismatches,
	output int         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] byte_on_top;
		logic       holds_bytes;
		logic       is_balanced;
		logic       dropped;
	} stack_status_t;

	logic [7:0]    stack_mem [DEPTH];
	int            stack_fill = 0;
	stack_status_t status_q [$];
	int            fault_count = 0;
	int            queued = 0;

	assign mismatches  = fault_count;
	assign outstanding = queued;

	// Walk the stored bytes bottom to top; a closer cancels its own opener on top
	function automatic logic contents_balanced();
		logic [7:0] unmatched [$];
		logic       closes;
		for (int i = 0; i < stack_fill; i++) begin
			closes = unmatched.size() > 0 &&
				((stack_mem[i] == CH_RPAREN && unmatched[$] == CH_LPAREN) ||
				 (stack_mem[i] == CH_RBRACE && unmatched[$] == CH_LBRACE) ||
				 (stack_mem[i] == CH_RBRACK && unmatched[$] == CH_LBRACK));
			if (closes) begin
				void'(unmatched.pop_back());
			end else begin
				unmatched.push_back(stack_mem[i]);
			end
		end
		return unmatched.size() == 0;
	endfunction

	// Apply one command to the local stack and form the status it reports
	function automatic stack_status_t apply_command(input logic [1:0] cmd,
		input logic [7:0] ch);
		stack_status_t st;
		st = '0;
		case (cmd)
			CMD_PUSH: begin
				if (stack_fill < DEPTH) begin
					stack_mem[stack_fill] = ch;
					stack_fill++;
				end else begin
					st.dropped = 1'b1;
				end
			end
			CMD_POP: begin
				if (stack_fill > 0) stack_fill--;
			end
			CMD_CHECK: begin
				st.is_balanced = contents_balanced();
			end
			CMD_TOP: begin
			end
			default: begin
			end
		endcase
		if (stack_fill > 0) begin
			st.byte_on_top = stack_mem[stack_fill - 1];
			st.holds_bytes = 1'b1;
		end
		return st;
	endfunction

	function automatic void compare_field(input string field, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
			fault_count++;
		end
	endfunction

	// Retire result beats first, then predict the command beat of this edge
	always @(posedge clk) begin
		stack_status_t want;
		if (arst_n) begin
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (status_q.size() == 0) begin
					$display("%0t: result beat with none expected, actual %0h/%b/%b/%b",
						$time, top_char, top_valid, balanced, overflow);
					fault_count++;
				end else begin
					want = status_q.pop_front();
					compare_field("top_char", want.byte_on_top, top_char);
					compare_field("top_valid", 8'(want.holds_bytes), 8'(top_valid));
					compare_field("balanced", 8'(want.is_balanced), 8'(balanced));
					compare_field("overflow", 8'(want.dropped), 8'(overflow));
				end
			end
			if (in_valid === 1'b1 && in_ready === 1'b1) begin
				status_q.push_back(apply_command(command, char_in));
			end
			queued <= status_q.size();
		end
	end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Bracket balance stack - testbench top
// Drives command beats into the bracket balance stack: a short directed run
// over the corner cases, then random nested bracket strings (mostly well
// formed, some damaged), loose random commands and one fill past full.
// Both channels idle at random; the checker beside the block predicts and
// compares, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bbs_pkg::*;

	localparam int ITEMS        = 1050;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 12;
	localparam int CALM_FIRST   = 150;
	localparam int CALM_LAST    = 320;

	localparam logic [2:0][7:0] OPENERS = {CH_LBRACK, CH_LBRACE, CH_LPAREN};
	localparam logic [2:0][7:0] CLOSERS = {CH_RBRACK, CH_RBRACE, CH_RPAREN};

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [1:0] command   = CMD_TOP;
	logic [7:0] char_in   = 8'h00;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] top_char;
	logic       top_valid;
	logic       balanced;
	logic       overflow;
	int         mismatches;
	int         outstanding;

	int         sent_beats   = 0;
	int         stack_depth  = 0;
	int         quiet_cycles = 0;
	logic       calm;
	logic [7:0] bracket_run [$];

	bracket_balance_stack_top dut (.*);

	bracket_stack_checker checker_i (.*);

	always #5 clk = ~clk;

	// No idling on either side through one stretch of the run
	assign calm = sent_beats >= CALM_FIRST && sent_beats < CALM_LAST;

	// Stall the result side at random
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 17);
	end

	// End the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Half brackets, half any byte
	function automatic logic [7:0] any_byte();
		int k;
		k = $urandom_range(0, 2);
		if ($urandom_range(0, 1)) return $urandom_range(0, 1) ? OPENERS[k] : CLOSERS[k];
		return 8'($urandom_range(0, 255));
	endfunction

	// Offer one command beat, idling first at random, and hold it until taken
	task automatic send_beat(input logic [1:0] cmd, input logic [7:0] ch);
		while (!calm && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		char_in  <= ch;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_beats++;
		if (cmd == CMD_PUSH && stack_depth < BBS_DEPTH) stack_depth++;
		if (cmd == CMD_POP && stack_depth > 0) stack_depth--;
	endtask

	task automatic pop_to(input int target);
		while (stack_depth > target) send_beat(CMD_POP, any_byte());
	endtask

	// Build a properly nested bracket string of the given number of pairs
	task automatic build_nest(input int pairs);
		logic [7:0] closers_due [$];
		int         opens_left;
		int         k;
		bracket_run.delete();
		opens_left = pairs;
		while (opens_left > 0 || closers_due.size() > 0) begin
			if (opens_left > 0 && (closers_due.size() == 0 || $urandom_range(0, 1))) begin
				k = $urandom_range(0, 2);
				bracket_run.push_back(OPENERS[k]);
				closers_due.push_back(CLOSERS[k]);
				opens_left--;
			end else begin
				bracket_run.push_back(closers_due.pop_back());
			end
		end
	endtask

	task automatic push_run();
		foreach (bracket_run[i]) send_beat(CMD_PUSH, bracket_run[i]);
	endtask

	initial begin : stimulus
		logic       filled;
		logic [1:0] cmd;
		int         pick;
		int         room;
		filled = 1'b0;

		// Hold reset, then release it
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stack: read top, pop, check
		send_beat(CMD_TOP, 8'h00);
		send_beat(CMD_POP, 8'hFF);
		send_beat(CMD_CHECK, 8'h00);
		// Matched pair, then a closer of the wrong kind
		send_beat(CMD_PUSH, CH_LPAREN);
		send_beat(CMD_PUSH, CH_RPAREN);
		send_beat(CMD_CHECK, 8'h5A);
		send_beat(CMD_PUSH, CH_LBRACK);
		send_beat(CMD_PUSH, CH_RBRACE);
		send_beat(CMD_CHECK, 8'hA5);
		// Byte extremes
		send_beat(CMD_PUSH, 8'h00);
		send_beat(CMD_PUSH, 8'hFF);
		send_beat(CMD_TOP, 8'hA5);
		send_beat(CMD_CHECK, 8'h00);
		// Drain, then pop once more on empty
		pop_to(0);
		send_beat(CMD_POP, 8'h00);
		// Crossed pairs never match
		send_beat(CMD_PUSH, CH_LPAREN);
		send_beat(CMD_PUSH, CH_LBRACK);
		send_beat(CMD_PUSH, CH_RPAREN);
		send_beat(CMD_PUSH, CH_RBRACK);
		send_beat(CMD_CHECK, 8'hFF);

		while (sent_beats < ITEMS) begin
			pick = $urandom_range(0, 99);
			if (!filled && sent_beats >= 480) begin
				// Fill to the brim with nested strings, overrun, then unwind
				filled = 1'b1;
				pop_to(0);
				while (stack_depth < BBS_DEPTH) begin
					room = (BBS_DEPTH - stack_depth) / 2;
					build_nest($urandom_range(1, room < 16 ? room : 16));
					push_run();
				end
				send_beat(CMD_CHECK, any_byte());
				repeat (3) send_beat(CMD_PUSH, 8'($urandom_range(0, 255)));
				send_beat(CMD_TOP, any_byte());
				send_beat(CMD_POP, any_byte());
				send_beat(CMD_PUSH, CH_RPAREN);
				send_beat(CMD_CHECK, any_byte());
				while (stack_depth > 0) begin
					pick = $urandom_range(0, 39);
					cmd  = pick == 0 ? CMD_CHECK : (pick == 1 ? CMD_TOP : CMD_POP);
					send_beat(cmd, any_byte());
				end
			end else if (pick < 60) begin
				// Nested string, now and then damaged, checked and unwound
				if ($urandom_range(0, 1)) pop_to(0);
				build_nest($urandom_range(1, 8));
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					bracket_run[$urandom_range(0, bracket_run.size() - 1)] = any_byte();
				end else if (pick == 1) begin
					bracket_run.delete($urandom_range(0, bracket_run.size() - 1));
				end
				push_run();
				send_beat(CMD_CHECK, any_byte());
				if ($urandom_range(0, 1)) send_beat(CMD_TOP, any_byte());
				pop_to(stack_depth - bracket_run.size());
				if ($urandom_range(0, 3) == 0) send_beat(CMD_CHECK, any_byte());
			end else begin
				// Loose command; lean toward pops once the stack grows
				cmd = 2'($urandom_range(0, 3));
				if (cmd == CMD_PUSH && stack_depth > 24 && $urandom_range(0, 1)) cmd = CMD_POP;
				send_beat(cmd, any_byte());
			end
		end
		in_valid <= 1'b0;

		// Let the count take the last beat, then wait out the last results
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bbs_pkg.sv
rtl/bbs_match_walker.sv
rtl/bracket_balance_stack_top.sv
dv/bracket_stack_checker.sv
dv/tb.sv
